>>> sv/servo_pid_hold_controller_top_assert.svh
// Assertion macros for the servo axis PID hold controller.
// Expects clk_i and rst_ni in the scope that uses them.
`ifndef SERVO_PID_HOLD_CONTROLLER_TOP_ASSERT_SVH
`define SERVO_PID_HOLD_CONTROLLER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SVPHC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SVPHC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/svphc_pkg.sv
// Shared types and constants for the servo axis PID hold controller.
// No dependencies; used by every module of the block.
`default_nettype none

package svphc_pkg;

  localparam int POS_W   = 12;
  localparam int ERR_W   = POS_W + 1;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int GAIN_W  = 16;
  localparam int FRAC_W  = 8;
  localparam int SLIM_W  = 9;
  localparam int ILIM_W  = 10;
  localparam int INTEG_W = 11;
  localparam int THR_W   = 12;
  localparam int VEL_W   = 10;
  localparam int VEL_SAT = 265;

  localparam int PP_W  = GAIN_W + 1 + ERR_W;
  localparam int IP_W  = GAIN_W + 1 + INTEG_W;
  localparam int DP_W  = GAIN_W + 1 + DIFF_W;
  localparam int SUM_W = DP_W + 2;
  localparam int QUO_W = SUM_W - FRAC_W;

  localparam int DATA_W  = 32;
  localparam int PADDR_W = 5;
  localparam int REGI_W  = 3;

  // register indexes, byte address 4*index
  localparam logic [REGI_W-1:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [REGI_W-1:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [REGI_W-1:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [REGI_W-1:0] REG_SPEED_LIMIT = 3'd3;
  localparam logic [REGI_W-1:0] REG_INTEG_LIMIT = 3'd4;
  localparam logic [REGI_W-1:0] REG_HOLD_THRESH = 3'd5;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST   = 16'd256;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST  = 16'd0;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST  = 16'd0;
  localparam logic [SLIM_W-1:0] SPEED_LIMIT_RST = 9'd265;
  localparam logic [ILIM_W-1:0] INTEG_LIMIT_RST = 10'd100;
  localparam logic [THR_W-1:0]  HOLD_THRESH_RST = 12'd15;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_TARGET = 2'd1,
    KIND_ESTOP  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [POS_W-1:0] meas;
    logic [POS_W-1:0] tgt;
  } item_t;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integ_gain;
    logic [GAIN_W-1:0] deriv_gain;
    logic [SLIM_W-1:0] speed_limit;
    logic [ILIM_W-1:0] integ_limit;
    logic [THR_W-1:0]  hold_thresh;
  } cfg_t;

  // error terms of one sample after the state update
  typedef struct packed {
    logic [ERR_W-1:0]   err;
    logic [INTEG_W-1:0] acc;
    logic [DIFF_W-1:0]  derr;
    logic               gate;
    logic               hold;
  } trk_t;

endpackage

`default_nettype wire

>>> sv/svphc_regs.sv
// Configuration register file of the servo axis PID hold controller.
// APB-style write/read port; depends on svphc_pkg.
`default_nettype none

module svphc_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [svphc_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [svphc_pkg::DATA_W-1:0]   pwdata,
  output logic      [svphc_pkg::DATA_W-1:0]   prdata,
  output logic                                pready,
  output svphc_pkg::cfg_t                     cfg_o
);
  import svphc_pkg::*;

  cfg_t              cfg_q, cfg_d;
  logic              wr_en;
  logic [REGI_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_PROP_GAIN:   cfg_d.prop_gain   = pwdata[GAIN_W-1:0];
        REG_INTEG_GAIN:  cfg_d.integ_gain  = pwdata[GAIN_W-1:0];
        REG_DERIV_GAIN:  cfg_d.deriv_gain  = pwdata[GAIN_W-1:0];
        REG_SPEED_LIMIT: cfg_d.speed_limit = pwdata[SLIM_W-1:0];
        REG_INTEG_LIMIT: cfg_d.integ_limit = pwdata[ILIM_W-1:0];
        REG_HOLD_THRESH: cfg_d.hold_thresh = pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PROP_GAIN:   prdata = DATA_W'(cfg_q.prop_gain);
      REG_INTEG_GAIN:  prdata = DATA_W'(cfg_q.integ_gain);
      REG_DERIV_GAIN:  prdata = DATA_W'(cfg_q.deriv_gain);
      REG_SPEED_LIMIT: prdata = DATA_W'(cfg_q.speed_limit);
      REG_INTEG_LIMIT: prdata = DATA_W'(cfg_q.integ_limit);
      REG_HOLD_THRESH: prdata = DATA_W'(cfg_q.hold_thresh);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain   <= PROP_GAIN_RST;
      cfg_q.integ_gain  <= INTEG_GAIN_RST;
      cfg_q.deriv_gain  <= DERIV_GAIN_RST;
      cfg_q.speed_limit <= SPEED_LIMIT_RST;
      cfg_q.integ_limit <= INTEG_LIMIT_RST;
      cfg_q.hold_thresh <= HOLD_THRESH_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> sv/svphc_track.sv
// Axis state stage: target, clamped integral, last error and hold flag.
// Forms the error terms of each sample; depends on svphc_pkg.
`default_nettype none

module svphc_track (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  svphc_pkg::item_t          item_i,
  output logic                      ready_o,
  input  svphc_pkg::cfg_t           cfg_i,
  output logic                      valid_o,
  output svphc_pkg::trk_t           trk_o,
  input  wire logic                 ready_i
);
  import svphc_pkg::*;

  logic [POS_W-1:0]   target_q, target_d;
  logic [INTEG_W-1:0] integ_q, integ_d;
  logic [ERR_W-1:0]   last_q, last_d;
  logic               hold_q, hold_d;
  logic               v1_q, v1_d;
  trk_t               trk_q, trk_d;

  logic               take;
  logic signed [ERR_W-1:0]  err;
  logic signed [ERR_W-1:0]  last_s;
  logic signed [DIFF_W-1:0] isum, ilim_s, iclamp;
  logic signed [DIFF_W-1:0] derr;
  logic [ERR_W-1:0]         mag;
  logic                     flip;

  assign ready_o = ~v1_q | ready_i;
  assign take    = valid_i & ready_o;

  assign err    = $signed({1'b0, target_q}) - $signed({1'b0, item_i.meas});
  assign last_s = $signed(last_q);
  assign isum   = $signed({{(DIFF_W-INTEG_W){integ_q[INTEG_W-1]}}, integ_q})
                + $signed({err[ERR_W-1], err});
  assign ilim_s = $signed({{(DIFF_W-ILIM_W){1'b0}}, cfg_i.integ_limit});
  assign derr   = $signed({err[ERR_W-1], err}) - $signed({last_s[ERR_W-1], last_s});
  assign mag    = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);

  // zero on either side is not a sign change
  assign flip = ((err > 0) && (last_s < 0)) || ((err < 0) && (last_s > 0));

  always_comb begin
    if (isum > ilim_s) begin
      iclamp = ilim_s;
    end else if (isum < -ilim_s) begin
      iclamp = -ilim_s;
    end else begin
      iclamp = isum;
    end
  end

  always_comb begin
    target_d = target_q;
    integ_d  = integ_q;
    last_d   = last_q;
    hold_d   = hold_q;
    trk_d    = trk_q;
    v1_d     = ready_o ? 1'b0 : v1_q;
    if (take) begin
      case (item_i.kind)
        KIND_SAMPLE: begin
          integ_d    = flip ? '0 : iclamp[INTEG_W-1:0];
          last_d     = err;
          hold_d     = (mag < {1'b0, cfg_i.hold_thresh});
          v1_d       = 1'b1;
          trk_d.err  = err;
          trk_d.acc  = integ_d;
          trk_d.derr = derr;
          trk_d.gate = hold_q;
          trk_d.hold = hold_d;
        end
        KIND_TARGET: begin
          target_d = item_i.tgt;
          hold_d   = 1'b0;
        end
        KIND_ESTOP: begin
          // zero terms give a zero velocity downstream
          hold_d     = 1'b1;
          v1_d       = 1'b1;
          trk_d.err  = '0;
          trk_d.acc  = '0;
          trk_d.derr = '0;
          trk_d.gate = 1'b1;
          trk_d.hold = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      integ_q  <= '0;
      last_q   <= '0;
      hold_q   <= 1'b0;
      v1_q     <= 1'b0;
    end else begin
      target_q <= target_d;
      integ_q  <= integ_d;
      last_q   <= last_d;
      hold_q   <= hold_d;
      v1_q     <= v1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    trk_q <= trk_d;
  end

  assign valid_o = v1_q;
  assign trk_o   = trk_q;

endmodule

`default_nettype wire

>>> sv/svphc_out.sv
// Output stages: gain products, then sum, truncation, saturation and hold gating.
// Holds the result register toward the consumer; depends on svphc_pkg.
`default_nettype none

module svphc_out (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            valid_i,
  input  svphc_pkg::trk_t                      trk_i,
  output logic                                 ready_o,
  input  svphc_pkg::cfg_t                      cfg_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic signed [svphc_pkg::VEL_W-1:0]   velocity_o,
  output logic                                 holding_o,
  output logic signed [svphc_pkg::ERR_W-1:0]   position_error_o
);
  import svphc_pkg::*;

  localparam logic [SLIM_W-1:0] SAT_LIM = SLIM_W'(VEL_SAT);

  logic                     v2_q, v3_q;
  logic                     r3;
  logic signed [PP_W-1:0]   pp_d, pp_q;
  logic signed [IP_W-1:0]   ip_d, ip_q;
  logic signed [DP_W-1:0]   dp_d, dp_q;
  logic [ERR_W-1:0]         err2_q;
  logic                     gate2_q, hold2_q;

  logic signed [SUM_W-1:0]  sum, adj;
  logic signed [QUO_W-1:0]  quo, lim_s, vel;
  logic [SLIM_W-1:0]        lim;
  logic [VEL_W-1:0]         vel_d, vel_q;
  logic                     hold3_q;
  logic [ERR_W-1:0]         err3_q;

  assign r3      = ~v3_q | ~out_stall_i;
  assign ready_o = ~v2_q | r3;

  assign pp_d = $signed({1'b0, cfg_i.prop_gain})  * $signed(trk_i.err);
  assign ip_d = $signed({1'b0, cfg_i.integ_gain}) * $signed(trk_i.acc);
  assign dp_d = $signed({1'b0, cfg_i.deriv_gain}) * $signed(trk_i.derr);

  assign sum = SUM_W'(pp_q) + SUM_W'(ip_q) + SUM_W'(dp_q);
  // bias negatives so the shift truncates toward zero
  assign adj = sum + (sum[SUM_W-1] ? SUM_W'((1 << FRAC_W) - 1) : SUM_W'(0));
  assign quo = adj[SUM_W-1:FRAC_W];

  assign lim   = (cfg_i.speed_limit > SAT_LIM) ? SAT_LIM : cfg_i.speed_limit;
  assign lim_s = $signed({{(QUO_W-SLIM_W){1'b0}}, lim});

  always_comb begin
    if (quo > lim_s) begin
      vel = lim_s;
    end else if (quo < -lim_s) begin
      vel = -lim_s;
    end else begin
      vel = quo;
    end
    vel_d = gate2_q ? '0 : vel[VEL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ready_o) begin
        v2_q <= valid_i;
      end
      if (r3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      pp_q    <= pp_d;
      ip_q    <= ip_d;
      dp_q    <= dp_d;
      err2_q  <= trk_i.err;
      gate2_q <= trk_i.gate;
      hold2_q <= trk_i.hold;
    end
    if (r3 && v2_q) begin
      vel_q   <= vel_d;
      hold3_q <= hold2_q;
      err3_q  <= err2_q;
    end
  end

  assign out_valid_o      = v3_q;
  assign velocity_o       = $signed(vel_q);
  assign holding_o        = hold3_q;
  assign position_error_o = $signed(err3_q);

endmodule

`default_nettype wire

>>> sv/servo_pid_hold_controller_top.sv
// Top level of one servo axis PID hold controller: input register, axis state
// stage, output stages and register file. Depends on svphc_pkg and the assert header.
`default_nettype none

`include "servo_pid_hold_controller_top_assert.svh"

// One servo axis. Accepts one beat per clock while in_stall_o is low; a position
// sample or an emergency stop presents one result after it passes the input
// register, state stage, product register and result register in that order;
// a set-target or unused kind gives none.
// The target, integral, last error and hold flag update in the single state
// stage, so back-to-back samples see each other's state with no wait. The input
// side keeps taking beats while a result waits, as long as a stage ahead is free.
// Registers at byte addresses 0x00..0x14: prop_gain, integ_gain, deriv_gain,
// axis_speed_limit, integ_limit, hold_threshold; write them only while idle.
module servo_pid_hold_controller_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [1:0]                      kind_i,
  input  wire logic [svphc_pkg::POS_W-1:0]     measured_position_i,
  input  wire logic [svphc_pkg::POS_W-1:0]     target_position_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic signed [svphc_pkg::VEL_W-1:0]   velocity_o,
  output logic                                 holding_o,
  output logic signed [svphc_pkg::ERR_W-1:0]   position_error_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [svphc_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [svphc_pkg::DATA_W-1:0]    pwdata,
  output logic      [svphc_pkg::DATA_W-1:0]    prdata,
  output logic                                 pready
);
  import svphc_pkg::*;

  localparam logic signed [VEL_W-1:0] VEL_MAX = VEL_W'(VEL_SAT);

  logic  v0_q;
  item_t item_q;
  logic  r0, r1, r2;
  logic  v1;
  trk_t  trk;
  cfg_t  cfg;
  logic  vel_in_range;

  assign r0         = ~v0_q | r1;
  assign in_stall_o = ~r0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (r0) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r0 && in_valid_i) begin
      item_q.kind <= kind_e'(kind_i);
      item_q.meas <= measured_position_i;
      item_q.tgt  <= target_position_i;
    end
  end

  svphc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  svphc_track u_track (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v0_q),
    .item_i  (item_q),
    .ready_o (r1),
    .cfg_i   (cfg),
    .valid_o (v1),
    .trk_o   (trk),
    .ready_i (r2)
  );

  svphc_out u_out (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (v1),
    .trk_i            (trk),
    .ready_o          (r2),
    .cfg_i            (cfg),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .velocity_o       (velocity_o),
    .holding_o        (holding_o),
    .position_error_o (position_error_o)
  );

  assign vel_in_range = (velocity_o <= VEL_MAX) && (velocity_o >= -VEL_MAX);

  `SVPHC_ASSERT_NOW(a_vel_bound, out_valid_o, vel_in_range, "velocity beyond saturation")
  `SVPHC_ASSERT_NEXT(a_in_capture, in_valid_i && !in_stall_o, v0_q, "accepted beat not captured")
  `SVPHC_ASSERT_NEXT(a_s0_hold, v0_q && !r1, v0_q, "input stage item lost while blocked")
  `SVPHC_ASSERT_NEXT(a_s1_hold, v1 && !r2, v1, "state stage item lost while blocked")

endmodule

`default_nettype wire
